// ===== design/ntcb_pkg.sv =====
// shared types and constants for the ntc beta temperature pipeline
// no dependencies; used by every module of the block
package ntcb_pkg;

    // status codes on the output
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_HIGH = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_REFERENCE = 2'd0;
    localparam logic [1:0] REG_SERIES    = 2'd1;
    localparam logic [1:0] REG_NOMINAL   = 2'd2;
    localparam logic [1:0] REG_BETA      = 2'd3;

    localparam logic [12:0] RST_REFERENCE = 13'd3300;
    localparam logic [19:0] RST_SERIES    = 20'd100000;
    localparam logic [19:0] RST_NOMINAL   = 20'd100000;
    localparam logic [13:0] RST_BETA      = 14'd3950;

    // fixed point constants
    localparam logic [23:0] LN2_Q24     = 24'd11629080;
    localparam logic [30:0] D_SCALE     = 31'd1677721600;  // 100 * 2^24
    localparam logic [14:0] T25_CENTI   = 15'd29815;
    localparam logic [15:0] CK_SAT      = 16'd60083;       // first saturating centikelvin
    localparam logic signed [15:0] TEMP_MAX   = 16'sh7FFF;
    localparam logic signed [15:0] TEMP_MIN   = -16'sd27315;
    localparam logic signed [16:0] ZERO_CENTI = 17'sd27315;

    localparam int LOG_STAGES = 25;
    localparam int DIV_STAGES = 16;

    // outcome fixed ahead of the arithmetic
    typedef struct packed {
        logic               spec;
        logic [1:0]         status;
        logic signed [15:0] temp;
    } t_tag;

endpackage

// ===== design/ntc_beta_temperature.sv =====
// ntc_beta_temperature: throughput one item per cycle; the whole pipeline holds
// while the output stalls. the pipeline runs through the input stage, the normalize and
// 24 squaring stages of the log units, seven arithmetic stages, the 16 divider stages
// and the output register
// synchronous active-low reset clears valid bits and restores register defaults
// depends on ntcb_pkg, ntcb_log2, ntcb_div
module ntc_beta_temperature (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [19:0] i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [12:0] voltage_mv
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [15:0] temp_centi_c
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    localparam int NL = ntcb_pkg::LOG_STAGES;
    localparam int ND = ntcb_pkg::DIV_STAGES;

    logic [12:0] r_ref;
    logic [19:0] r_rs;
    logic [19:0] r_r25;
    logic [13:0] r_beta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref  <= ntcb_pkg::RST_REFERENCE;
            r_rs   <= ntcb_pkg::RST_SERIES;
            r_r25  <= ntcb_pkg::RST_NOMINAL;
            r_beta <= ntcb_pkg::RST_BETA;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ntcb_pkg::REG_REFERENCE: r_ref  <= i_cfg_data[12:0];
                ntcb_pkg::REG_SERIES:    r_rs   <= i_cfg_data;
                ntcb_pkg::REG_NOMINAL:   r_r25  <= i_cfg_data;
                ntcb_pkg::REG_BETA:      r_beta <= i_cfg_data[13:0];
                default: ;
            endcase
        end
    end

    logic w_en;
    logic r_o_vld;
    assign w_en       = !r_o_vld || i_m_tready;
    assign o_s_tready = w_en;

    // valid line
    logic            r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_f_vld, r_g_vld, r_h_vld;
    logic            r_vl [0:NL-1];
    logic            r_vt [0:ND-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
            r_h_vld <= 1'b0;
            r_o_vld <= 1'b0;
            for (int i = 0; i < NL; i++) r_vl[i] <= 1'b0;
            for (int i = 0; i < ND; i++) r_vt[i] <= 1'b0;
        end else if (w_en) begin
            r_a_vld <= i_s_tvalid;
            r_vl[0] <= r_a_vld;
            for (int i = 1; i < NL; i++) r_vl[i] <= r_vl[i-1];
            r_b_vld <= r_vl[NL-1];
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
            r_h_vld <= r_g_vld;
            r_vt[0] <= r_h_vld;
            for (int i = 1; i < ND; i++) r_vt[i] <= r_vt[i-1];
            r_o_vld <= r_vt[ND-1];
        end
    end

    // stage a: divider products and early outcomes
    logic [12:0]     w_v;
    logic [12:0]     w_diff;
    ntcb_pkg::t_tag  n_a_tag;
    logic [32:0]     r_a_num, r_a_den;
    ntcb_pkg::t_tag  r_a_tag;

    assign w_v    = i_s_tdata[12:0];
    assign w_diff = r_ref - w_v;

    always_comb begin
        n_a_tag = '{spec: 1'b0, status: ntcb_pkg::ST_OK, temp: 16'sd0};
        if (w_v == 13'd0) begin
            n_a_tag = '{spec: 1'b1, status: ntcb_pkg::ST_ZERO, temp: 16'sd0};
        end else if (w_v >= r_ref) begin
            n_a_tag = '{spec: 1'b1, status: ntcb_pkg::ST_HIGH, temp: 16'sd0};
        end else if (r_rs == 20'd0 || r_r25 == 20'd0) begin
            n_a_tag = '{spec: 1'b1, status: ntcb_pkg::ST_SAT, temp: ntcb_pkg::TEMP_MIN};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_num <= {20'd0, w_v} * {13'd0, r_rs};
            r_a_den <= {20'd0, w_diff} * {13'd0, r_r25};
            r_a_tag <= n_a_tag;
        end
    end

    logic [29:0] w_lnum, w_lden;

    ntcb_log2 u_log_num (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r_a_num),
        .o_log (w_lnum)
    );

    ntcb_log2 u_log_den (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (r_a_den),
        .o_log (w_lden)
    );

    ntcb_pkg::t_tag r_tl [0:NL-1];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tl[0] <= r_a_tag;
            for (int i = 1; i < NL; i++) r_tl[i] <= r_tl[i-1];
        end
    end

    // stages b..h: log difference, ln scaling, reciprocal terms, saturation test
    logic signed [30:0] r_b_l;
    ntcb_pkg::t_tag     r_b_tag, r_c_tag, r_d_tag, r_e_tag, r_f_tag, r_g_tag, r_h_tag;
    logic               r_c_neg;
    logic [53:0]        r_c_prod;
    logic signed [30:0] r_d_lnq;
    logic [44:0]        r_e_db;
    logic signed [45:0] r_e_dl;
    logic [28:0]        r_e_bn;
    logic signed [47:0] r_f_d;
    logic [59:0]        r_f_n;
    logic [59:0]        r_g_nn;
    logic [46:0]        r_g_d;
    logic [62:0]        r_g_lim;
    logic [59:0]        r_h_nn;
    logic [46:0]        r_h_d;

    logic [30:0]        w_lmag;
    logic [53:0]        w_round;
    logic [30:0]        w_lnmag;
    ntcb_pkg::t_tag     n_g_tag, n_h_tag;

    assign w_lmag  = r_b_l[30] ? 31'(-r_b_l) : 31'(r_b_l);
    assign w_round = r_c_prod + 54'd8388608;
    assign w_lnmag = {1'b0, w_round[53:24]};

    always_comb begin
        n_g_tag = r_f_tag;
        if (!r_f_tag.spec && r_f_d == 48'sd0) begin
            n_g_tag = '{spec: 1'b1, status: ntcb_pkg::ST_SAT, temp: ntcb_pkg::TEMP_MAX};
        end else if (!r_f_tag.spec && r_f_d < 48'sd0) begin
            n_g_tag = '{spec: 1'b1, status: ntcb_pkg::ST_SAT, temp: ntcb_pkg::TEMP_MIN};
        end
        n_h_tag = r_g_tag;
        if (!r_g_tag.spec && ({4'd0, r_g_nn} >= {1'b0, r_g_lim})) begin
            n_h_tag = '{spec: 1'b1, status: ntcb_pkg::ST_SAT, temp: ntcb_pkg::TEMP_MAX};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b_l    <= $signed({1'b0, w_lnum}) - $signed({1'b0, w_lden});
            r_b_tag  <= r_tl[NL-1];

            r_c_neg  <= r_b_l[30];
            r_c_prod <= {24'd0, w_lmag[29:0]} * {30'd0, ntcb_pkg::LN2_Q24};
            r_c_tag  <= r_b_tag;

            r_d_lnq  <= r_c_neg ? -$signed(w_lnmag) : $signed(w_lnmag);
            r_d_tag  <= r_c_tag;

            r_e_db   <= {31'd0, r_beta} * {14'd0, ntcb_pkg::D_SCALE};
            r_e_dl   <= 46'(r_d_lnq) * $signed({31'd0, ntcb_pkg::T25_CENTI});
            r_e_bn   <= {15'd0, r_beta} * {14'd0, ntcb_pkg::T25_CENTI};
            r_e_tag  <= r_d_tag;

            r_f_d    <= $signed({3'd0, r_e_db}) + 48'(r_e_dl);
            r_f_n    <= {31'd0, r_e_bn} * {29'd0, ntcb_pkg::D_SCALE};
            r_f_tag  <= r_e_tag;

            r_g_nn   <= r_f_n + {14'd0, r_f_d[46:1]};
            r_g_d    <= r_f_d[46:0];
            r_g_lim  <= {16'd0, r_f_d[46:0]} * {47'd0, ntcb_pkg::CK_SAT};
            r_g_tag  <= n_g_tag;

            r_h_nn   <= r_g_nn;
            r_h_d    <= r_g_d;
            r_h_tag  <= n_h_tag;
        end
    end

    logic [15:0] w_q;

    ntcb_div u_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_nn  (r_h_nn),
        .i_d   (r_h_d),
        .o_q   (w_q)
    );

    ntcb_pkg::t_tag r_tt [0:ND-1];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tt[0] <= r_h_tag;
            for (int i = 1; i < ND; i++) r_tt[i] <= r_tt[i-1];
        end
    end

    // output register
    logic signed [16:0] w_temp;
    logic signed [15:0] r_o_temp;
    logic [1:0]         r_o_status;

    assign w_temp = $signed({1'b0, w_q}) - ntcb_pkg::ZERO_CENTI;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_tt[ND-1].spec) begin
                r_o_temp   <= r_tt[ND-1].temp;
                r_o_status <= r_tt[ND-1].status;
            end else begin
                r_o_temp   <= w_temp[15:0];
                r_o_status <= ntcb_pkg::ST_OK;
            end
        end
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = r_o_temp;
    assign o_m_tuser  = r_o_status;

endmodule

// ===== design/ntcb_log2.sv =====
// pipelined log2 in Q24: normalize stage, then one squaring round per stage
// depends on ntcb_pkg for the stage count
module ntcb_log2 (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [32:0] i_x,
    output logic [29:0] o_log
);

    localparam int NS = ntcb_pkg::LOG_STAGES;

    logic [5:0]  r_e [0:NS-1];
    logic [30:0] r_m [0:NS-1];
    logic [23:0] r_f [0:NS-1];

    logic [5:0]  n_e;
    logic [30:0] n_m;
    logic [63:0] w_shl;

    // top set bit and mantissa aligned to bit 30
    always_comb begin
        n_e = 6'd0;
        for (int i = 0; i < 33; i++) begin
            if (i_x[i]) n_e = 6'(i);
        end
        w_shl = {31'd0, i_x} << (6'd30 - n_e);
        if (n_e <= 6'd30) begin
            n_m = w_shl[30:0];
        end else begin
            n_m = 31'(i_x >> (n_e - 6'd30));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e[0] <= n_e;
            r_m[0] <= n_m;
            r_f[0] <= 24'd0;
        end
    end

    for (genvar j = 1; j < NS; j++) begin : g_round
        logic [61:0] w_sq;
        logic [31:0] w_t;
        assign w_sq = {31'd0, r_m[j-1]} * {31'd0, r_m[j-1]};
        assign w_t  = w_sq[61:30];
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_e[j] <= r_e[j-1];
                r_f[j] <= {r_f[j-1][22:0], w_t[31]};
                r_m[j] <= w_t[31] ? w_t[31:1] : w_t[30:0];
            end
        end
    end

    assign o_log = {r_e[NS-1], r_f[NS-1]};

endmodule

// ===== design/ntcb_div.sv =====
// pipelined restoring division giving a 16-bit quotient, one bit per stage
// depends on ntcb_pkg for the stage count; needs nn < d * 2^16 for a true quotient
module ntcb_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [59:0] i_nn,
    input  logic [46:0] i_d,
    output logic [15:0] o_q
);

    localparam int NS = ntcb_pkg::DIV_STAGES;

    logic [59:0] r_rem [0:NS-1];
    logic [46:0] r_d   [0:NS-1];
    logic [15:0] r_q   [0:NS-1];

    for (genvar j = 0; j < NS; j++) begin : g_bit
        logic [59:0] w_rem;
        logic [46:0] w_d;
        logic [15:0] w_q;
        logic [63:0] w_sub;
        logic        w_ge;
        if (j == 0) begin : g_first
            assign w_rem = i_nn;
            assign w_d   = i_d;
            assign w_q   = 16'd0;
        end else begin : g_next
            assign w_rem = r_rem[j-1];
            assign w_d   = r_d[j-1];
            assign w_q   = r_q[j-1];
        end
        assign w_sub = {17'd0, w_d} << (NS - 1 - j);
        assign w_ge  = {4'd0, w_rem} >= w_sub;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_d[j]   <= w_d;
                r_q[j]   <= {w_q[14:0], w_ge};
                r_rem[j] <= w_ge ? 60'({4'd0, w_rem} - w_sub) : w_rem;
            end
        end
    end

    assign o_q = r_q[NS-1];

endmodule

// ===== design/ntcb_checker.sv =====
// port-level checks for ntc_beta_temperature, attached with bind
// depends on ntcb_pkg for the status codes
module ntcb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result dropped while stalled");

    // a stalled result holds the input side too
    a_stall_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input accepted while output stalled");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // input flags carry a zero temperature
    a_flag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ntcb_pkg::ST_ZERO || o_m_tuser == ntcb_pkg::ST_HIGH)
        |-> o_m_tdata == 16'd0)
        else $error("flagged voltage with nonzero temperature");

    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == ntcb_pkg::ST_OK
        |-> $signed(o_m_tdata) >= ntcb_pkg::TEMP_MIN)
        else $error("temperature below absolute zero");

endmodule

bind ntc_beta_temperature ntcb_checker u_ntcb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

// ===== test/tb_top.sv =====
// testbench for ntc_beta_temperature: divider voltage in, temperature and status out
// an in-bench integer predictor gives the expected results; depends on ntcb_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic signed [15:0] temp;
        logic [1:0]         status;
    } t_reading;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_addr;
    logic [19:0] i_cfg_data;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [15:0] i_s_tdata;   // [12:0] voltage_mv
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [15:0] o_m_tdata;   // [15:0] temp_centi_c
    logic [1:0]  o_m_tuser;   // [1:0] status

    ntc_beta_temperature dut (.*);

    // predictor copy of the registers
    logic [12:0] ref_mv;
    logic [19:0] series_r;
    logic [19:0] nominal_r;
    logic [13:0] beta_k;

    t_reading expected_readings[$];
    int       n_errors;
    int       src_idle;
    int       dst_idle;

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic longint unsigned log2_fixed(longint unsigned x);
        int               e;
        longint unsigned  m;
        longint unsigned  frac;
        e = 0;
        frac = 0;
        while (e < 63 && (x >> (e + 1)) != 0) e++;
        m = (e <= 30) ? (x << (30 - e)) : (x >> (e - 30));
        for (int i = 0; i < 24; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                frac = frac | 64'd1;
                m = m >> 1;
            end
        end
        return (longint'(e) << 24) | frac;
    endfunction

    function automatic t_reading temperature_of(logic [12:0] v);
        t_reading        r;
        longint unsigned num, den, mag, ck;
        longint          l, lnq, d, n;
        r.temp = 16'sd0;
        if (v == 0) begin
            r.status = ntcb_pkg::ST_ZERO;
            return r;
        end
        if (v >= ref_mv) begin
            r.status = ntcb_pkg::ST_HIGH;
            return r;
        end
        r.status = ntcb_pkg::ST_SAT;
        r.temp = ntcb_pkg::TEMP_MIN;
        if (series_r == 0 || nominal_r == 0) return r;
        num = longint'(v) * longint'(series_r);
        den = longint'(ref_mv - v) * longint'(nominal_r);
        l = longint'(log2_fixed(num)) - longint'(log2_fixed(den));
        mag = (l < 0) ? -l : l;
        mag = (mag * 64'd11629080 + (64'd1 << 23)) >> 24;
        lnq = (l < 0) ? -longint'(mag) : longint'(mag);
        d = longint'(beta_k) * 64'sd1677721600 + 64'sd29815 * lnq;
        if (d == 0) begin
            r.temp = ntcb_pkg::TEMP_MAX;
            return r;
        end
        if (d < 0) return r;
        n = longint'(beta_k) * 64'sd29815 * 64'sd1677721600;
        ck = (longint'(unsigned'(n)) + (d >> 1)) / d;
        if (ck > 60082) begin
            r.temp = ntcb_pkg::TEMP_MAX;
            return r;
        end
        r.temp = 16'(longint'(ck) - 27315);
        r.status = ntcb_pkg::ST_OK;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // receiver side and result checking
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_readings.size() == 0) begin
                report_mismatch("unexpected item", int'($signed(o_m_tdata)), 0);
            end else begin
                want = expected_readings.pop_front();
                if ($signed(o_m_tdata) !== want.temp)
                    report_mismatch("temp_centi_c", int'($signed(o_m_tdata)), int'(want.temp));
                if (o_m_tuser !== want.status)
                    report_mismatch("status", int'(o_m_tuser), int'(want.status));
            end
        end
        i_m_tready <= ($urandom_range(99) >= dst_idle);
    end

    task automatic send_voltage(logic [12:0] v);
        while ($urandom_range(99) < src_idle) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {3'b000, v};
        do @(posedge i_clk); while (!o_s_tready);
        expected_readings.push_back(temperature_of(v));
    endtask

    // lets the pipeline empty before registers change
    task automatic drain;
        i_s_tvalid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_registers(logic [12:0] r, logic [19:0] s, logic [19:0] nom,
                                 logic [13:0] b);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_addr <= ntcb_pkg::REG_REFERENCE;
        i_cfg_data <= {7'd0, r};
        @(posedge i_clk);
        i_cfg_addr <= ntcb_pkg::REG_SERIES;
        i_cfg_data <= s;
        @(posedge i_clk);
        i_cfg_addr <= ntcb_pkg::REG_NOMINAL;
        i_cfg_data <= nom;
        @(posedge i_clk);
        i_cfg_addr <= ntcb_pkg::REG_BETA;
        i_cfg_data <= {6'd0, b};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        ref_mv = r;
        series_r = s;
        nominal_r = nom;
        beta_k = b;
    endtask

    task automatic test_directed;
        send_voltage(13'd0);
        send_voltage(13'd1);
        send_voltage(13'd1650);
        send_voltage(13'd3299);
        send_voltage(13'd3300);
        send_voltage(13'd8191);
        send_voltage(13'd100);
        // tiny resistance: too hot
        set_registers(13'd5000, 20'd1, 20'd1000000, 14'd10000);
        send_voltage(13'd1);
        send_voltage(13'd4999);
        // low beta with very small ratio: reciprocal temperature negative
        set_registers(13'd8191, 20'd1, 20'hFFFFF, 14'd1000);
        send_voltage(13'd1);
        send_voltage(13'd8190);
        send_voltage(13'd4096);
        // zero resistors
        set_registers(13'd1000, 20'd0, 20'd100000, 14'd16383);
        send_voltage(13'd500);
        set_registers(13'd1000, 20'd100000, 20'd0, 14'd3950);
        send_voltage(13'd500);
        // zero beta
        set_registers(13'd3300, 20'd100000, 20'd100000, 14'd0);
        send_voltage(13'd3000);
        send_voltage(13'd10);
        send_voltage(13'd1650);
    endtask

    task automatic random_registers;
        logic [12:0] r;
        logic [19:0] s, nom;
        logic [13:0] b;
        r = ($urandom_range(5) == 0) ? 13'h1FFF : 13'($urandom_range(1000, 5000));
        s = ($urandom_range(7) == 0) ? 20'($urandom) : 20'($urandom_range(1, 1000000));
        nom = ($urandom_range(7) == 0) ? 20'($urandom) : 20'($urandom_range(1, 1000000));
        b = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(1000, 10000));
        set_registers(r, s, nom, b);
    endtask

    task automatic test_random(int items, int s_idle, int d_idle);
        int k;
        logic [12:0] v;
        src_idle = s_idle;
        dst_idle = d_idle;
        for (k = 0; k < items; k++) begin
            if (k % 100 == 0) random_registers();
            // sender pause until everything is back
            if (k % 100 == 50) drain();
            case ($urandom_range(19))
                0: v = 13'd0;
                1: v = 13'($urandom);
                2: v = ref_mv;
                default: v = (ref_mv > 1) ? 13'($urandom_range(1, ref_mv - 1)) : 13'd1;
            endcase
            send_voltage(v);
        end
    endtask

    initial begin
        n_errors = 0;
        src_idle = 0;
        dst_idle = 0;
        ref_mv = ntcb_pkg::RST_REFERENCE;
        series_r = ntcb_pkg::RST_SERIES;
        nominal_r = ntcb_pkg::RST_NOMINAL;
        beta_k = ntcb_pkg::RST_BETA;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_addr <= ntcb_pkg::REG_REFERENCE;
        i_cfg_data <= 20'd0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= 16'd0;
        i_m_tready <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(430, 32, 82);
        test_random(430, 82, 32);
        test_random(440, 0, 0);
        drain();
        if (n_errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/ntcb_pkg.sv
design/ntcb_log2.sv
design/ntcb_div.sv
design/ntc_beta_temperature.sv
design/ntcb_checker.sv
test/tb_top.sv
